### hw/rtl/tsns_pkg.sv
// Shared types, constants and helper functions for the two-channel notify sequencer.
// No dependencies; every other file in hw/rtl imports this package.
package tsns_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int SLOT_BYTES_DEF = 20;

  localparam int KIND_W   = 4;
  localparam int MLEN_W   = 8;
  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 2;
  localparam int LEN_W    = 7;
  localparam int PAD_W    = 5;
  localparam int CRYPT_BLOCK = 16;
  localparam int LEN_MAX  = 127;

  typedef enum logic [KIND_W-1:0] {
    KIND_CONNECT       = 4'd0,
    KIND_DISCONNECT    = 4'd1,
    KIND_AUTH_OK       = 4'd2,
    KIND_ENABLE_CRYPT  = 4'd3,
    KIND_REPLY_WRITE   = 4'd4,
    KIND_UP_WRITE      = 4'd5,
    KIND_TX_COMPLETE   = 4'd6,
    KIND_TIMEOUT       = 4'd7,
    KIND_SEND_REJECTED = 4'd8
  } kind_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_SLOT      = 3'd1,
    ACT_CONTROL   = 3'd2,
    ACT_LEN_ERROR = 3'd3,
    ACT_DISCARDED = 3'd4
  } action_t;

  typedef enum logic {
    CH_REPLY = 1'b0,
    CH_UP    = 1'b1
  } chan_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MLEN_W-1:0] msg_length;
    logic              travel_mode;
  } in_item_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                channel;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    ctrl_length;
    logic                ctrl_encrypted;
    logic [LEN_W-1:0]    padded_length;
    logic [PAD_W-1:0]    pad_value;
    logic                arm_timer;
    logic                cancel_timer;
  } out_item_t;

  // Link and per-channel flags of the sequencer.
  typedef struct packed {
    logic       link_up;
    logic       crypt_on;
    logic       authed;
    logic       last_sender;
    logic [1:0] done;
    logic [1:0] pending;
    logic [1:0] crypt;
  } seq_flags_t;

  localparam seq_flags_t FLAGS_RESET = '{
    link_up: 1'b0, crypt_on: 1'b0, authed: 1'b0, last_sender: 1'b0,
    done: 2'b11, pending: 2'b00, crypt: 2'b00
  };

  function automatic int cap_limit(input int slot_count, input int slot_bytes);
    int raw;
    raw = slot_count * slot_bytes;
    return (raw > LEN_MAX) ? LEN_MAX : raw;
  endfunction

  function automatic int clog2_int(input int v);
    int r;
    r = 0;
    while ((1 << r) < v) begin
      r = r + 1;
    end
    return r;
  endfunction

endpackage

### hw/rtl/tsns_step.sv
// Next-state and result logic for one beat of the notify sequencer.
// Depends on tsns_pkg; instantiated by two_channel_segmented_notify_sequencer_core.
module tsns_step #(
  parameter int SLOT_COUNT = tsns_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = tsns_pkg::SLOT_BYTES_DEF,
  parameter int STEP_W     = 3
) (
  input  tsns_pkg::in_item_t   item,
  input  tsns_pkg::seq_flags_t flags,
  input  logic [STEP_W-1:0]    step      [2],
  input  logic [tsns_pkg::LEN_W-1:0] len [2],
  output tsns_pkg::seq_flags_t flags_nxt,
  output logic [STEP_W-1:0]    step_nxt  [2],
  output logic [tsns_pkg::LEN_W-1:0] len_nxt [2],
  output tsns_pkg::out_item_t  result
);
  import tsns_pkg::*;

  localparam int CapLimit = cap_limit(SLOT_COUNT, SLOT_BYTES);
  localparam int MaxSteps = (CapLimit + SLOT_BYTES - 1) / SLOT_BYTES;
  localparam int ProdMax  = MaxSteps * SLOT_BYTES;
  localparam int ProdBits = clog2_int(ProdMax + 1);
  localparam int PROD_W   = (ProdBits > LEN_W) ? ProdBits : LEN_W;
  localparam int PLEN_W   = MLEN_W + 1;

  logic              wr_ch;
  logic              sel;
  logic              do_write;
  logic              do_adv;
  logic              do_start;
  logic [1:0]        tick_done;
  logic [PAD_W-1:0]  pad;
  logic [PLEN_W-1:0] plen;
  logic [PROD_W-1:0] prod;
  logic              over_cap;

  always_comb begin
    if (flags.crypt_on) begin
      pad  = PAD_W'(CRYPT_BLOCK) - PAD_W'(item.msg_length[3:0]);
      plen = PLEN_W'(item.msg_length) + PLEN_W'(pad);
    end else begin
      pad  = '0;
      plen = PLEN_W'(item.msg_length);
    end
    over_cap = plen > PLEN_W'(CapLimit);
  end

  always_comb begin
    flags_nxt = flags;
    step_nxt  = step;
    len_nxt   = len;
    result    = '0;
    wr_ch     = CH_REPLY;
    sel       = CH_REPLY;
    do_write  = 1'b0;
    do_adv    = 1'b0;
    do_start  = 1'b0;
    tick_done = flags.done;
    prod      = '0;

    unique case (item.kind) inside
      KIND_CONNECT: begin
        flags_nxt.link_up  = 1'b1;
        flags_nxt.crypt_on = 1'b0;
        flags_nxt.authed   = 1'b0;
      end
      KIND_DISCONNECT: begin
        flags_nxt.link_up = 1'b0;
      end
      KIND_AUTH_OK: begin
        flags_nxt.authed = 1'b1;
      end
      KIND_ENABLE_CRYPT: begin
        flags_nxt.crypt_on = 1'b1;
      end
      KIND_REPLY_WRITE: begin
        wr_ch    = CH_REPLY;
        do_write = flags.link_up;
      end
      KIND_UP_WRITE: begin
        wr_ch = CH_UP;
        if (flags.link_up && flags.authed) begin
          if (!flags.done[CH_UP] || item.travel_mode) begin
            result.action  = ACT_DISCARDED;
            result.channel = CH_UP;
          end else begin
            do_write = 1'b1;
          end
        end
      end
      KIND_TX_COMPLETE, KIND_TIMEOUT: begin
        if (item.kind == KIND_TIMEOUT) begin
          tick_done = 2'b11;
        end
        flags_nxt.done = tick_done;
        if (!tick_done[CH_REPLY]) begin
          do_adv = 1'b1;
          sel    = CH_REPLY;
        end else if (!tick_done[CH_UP]) begin
          do_adv = 1'b1;
          sel    = CH_UP;
        end else if (flags.pending[CH_REPLY]) begin
          do_start = 1'b1;
          sel      = CH_REPLY;
        end else if (flags.pending[CH_UP]) begin
          do_start = 1'b1;
          sel      = CH_UP;
        end else begin
          result.cancel_timer = (item.kind != KIND_TIMEOUT);
        end
      end
      KIND_SEND_REJECTED: begin
        flags_nxt.done[flags.last_sender] = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_write) begin
      if (over_cap) begin
        result.action  = ACT_LEN_ERROR;
        result.channel = wr_ch;
      end else begin
        flags_nxt.pending[wr_ch] = 1'b1;
        flags_nxt.crypt[wr_ch]   = flags.crypt_on;
        len_nxt[wr_ch]           = LEN_W'(plen);
        step_nxt[wr_ch]          = '0;
        result.channel           = wr_ch;
        result.padded_length     = LEN_W'(plen);
        result.pad_value         = pad;
        if (flags.done[~wr_ch]) begin
          do_start = 1'b1;
          sel      = wr_ch;
        end
      end
    end

    if (do_adv) begin
      flags_nxt.last_sender = sel;
      prod = PROD_W'(step[sel]) * PROD_W'(SLOT_BYTES);
      result.channel   = sel;
      result.arm_timer = 1'b1;
      if (prod >= PROD_W'(len[sel])) begin
        flags_nxt.done[sel]   = 1'b1;
        result.action         = ACT_CONTROL;
        result.ctrl_length    = len[sel];
        result.ctrl_encrypted = flags.crypt[sel];
      end else begin
        step_nxt[sel] = step[sel] + STEP_W'(1);
        result.action = ACT_SLOT;
        result.slot   = SLOT_W'(step[sel]);
      end
    end

    if (do_start) begin
      flags_nxt.pending[sel] = 1'b0;
      flags_nxt.done[sel]    = 1'b0;
      flags_nxt.last_sender  = sel;
      result.action          = ACT_SLOT;
      result.channel         = sel;
      result.slot            = SLOT_W'(step_nxt[sel]);
      result.arm_timer       = 1'b1;
      step_nxt[sel]          = step_nxt[sel] + STEP_W'(1);
    end
  end

endmodule

### hw/rtl/two_channel_segmented_notify_sequencer_core.sv
// Top level of the two-channel segmented notify sequencer: state registers and output buffer.
// Depends on tsns_pkg and tsns_step.

// The block takes one event beat per clock cycle while in_ready is high and returns exactly
// one result beat for each. All state is updated in the cycle the event is accepted, so
// consecutive events never wait on each other. Results leave through a two-entry output
// buffer (output register plus skid register); in_ready depends only on that buffer and
// drops only when both entries hold results that the consumer has not yet taken.
module two_channel_segmented_notify_sequencer_core #(
  parameter int SLOT_COUNT = tsns_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = tsns_pkg::SLOT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tsns_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tsns_pkg::out_item_t out_data
);
  import tsns_pkg::*;

  localparam int CapLimit = cap_limit(SLOT_COUNT, SLOT_BYTES);
  localparam int MaxSteps = (CapLimit + SLOT_BYTES - 1) / SLOT_BYTES;
  localparam int STEP_W   = (clog2_int(MaxSteps + 1) < 1) ? 1 : clog2_int(MaxSteps + 1);

  seq_flags_t       flags_r;
  seq_flags_t       flags_nxt;
  logic [STEP_W-1:0] step_r   [2];
  logic [STEP_W-1:0] step_nxt [2];
  logic [LEN_W-1:0]  len_r    [2];
  logic [LEN_W-1:0]  len_nxt  [2];
  out_item_t        result;
  out_item_t        out_data_r;
  out_item_t        skid_data_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             accept;

  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tsns_step #(
    .SLOT_COUNT(SLOT_COUNT),
    .SLOT_BYTES(SLOT_BYTES),
    .STEP_W    (STEP_W)
  ) u_step (
    .item     (in_data),
    .flags    (flags_r),
    .step     (step_r),
    .len      (len_r),
    .flags_nxt(flags_nxt),
    .step_nxt (step_nxt),
    .len_nxt  (len_nxt),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= FLAGS_RESET;
      for (int i = 0; i < 2; i++) begin
        step_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else if (accept) begin
      flags_r <= flags_nxt;
      step_r  <= step_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= result;
      end
    end else if (accept) begin
      skid_data_r <= result;
    end
  end

endmodule
